FILE: design/ctok_pkg.sv
// ----------------------------------------------------------------------------
// ctok_pkg: shared definitions of the character stream tokenizer
// Scan modes, character constants, token classes, register indexes and the
// result record that travels from the step logic to the output queue.
// ----------------------------------------------------------------------------
package ctok_pkg;

    // Scan modes held in the state register.
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_INT     = 3'd2;
    localparam logic [2:0] MODE_NAME    = 3'd3;
    localparam logic [2:0] MODE_STR     = 3'd4;

    // Characters with a fixed meaning.
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // Token classes.
    localparam logic [1:0] CLS_END  = 2'd0;
    localparam logic [1:0] CLS_INT  = 2'd1;
    localparam logic [1:0] CLS_NAME = 2'd2;
    localparam logic [1:0] CLS_SIGN = 2'd3;

    // Input kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    // Register indexes, taken from paddr bit 2.
    localparam logic REG_QUOTE_BYTES = 1'b0;
    localparam logic REG_QUOTE_COUNT = 1'b1;

    // Number of quote byte slots.
    localparam int QUOTE_SLOTS = 4;

    // Output queue depth; an item never causes more results than this.
    localparam int OUT_DEPTH = 2;

    // One result.
    typedef struct packed {
        logic [1:0] token_class;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       starts_token;
        logic       space_before;
        logic       closes_token;
        logic       last_result;
    } res_t;

    // Everything one step produces: results and the next state.
    typedef struct packed {
        res_t       r0;
        res_t       r1;
        logic [1:0] n;
        logic [2:0] mode_next;
        logic [7:0] open_quote_next;
        logic       spaces_next;
    } step_t;

endpackage

FILE: design/ctok_ifs.sv
// ----------------------------------------------------------------------------
// ctok_ifs: stream channels of the character stream tokenizer
// The input channel carries one character or end mark per transaction, the
// output channel one token result per transaction.
// ----------------------------------------------------------------------------
interface ctok_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_byte;

    modport source (output valid, kind, char_byte, input ready);
    modport sink (input valid, kind, char_byte, output ready);
endinterface

interface ctok_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] token_class;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       starts_token;
    logic       space_before;
    logic       closes_token;
    logic       last_result;

    modport source (output valid, token_class, out_byte, byte_valid, starts_token,
                    space_before, closes_token, last_result, input ready);
    modport sink (input valid, token_class, out_byte, byte_valid, starts_token,
                  space_before, closes_token, last_result, output ready);
endinterface

FILE: design/ctok_regs.sv
// ----------------------------------------------------------------------------
// ctok_regs: configuration registers
// APB-style register file holding the quote bytes and the active quote count.
// ----------------------------------------------------------------------------
module ctok_regs
    import ctok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] quote_bytes,
    output logic [2:0]  quote_count
);

    logic [31:0] quote_bytes_reg;
    logic [2:0]  quote_count_reg;
    logic        wr_en;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_bytes_reg <= 32'd34;
            quote_count_reg <= 3'd1;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_QUOTE_BYTES: quote_bytes_reg <= pwdata;
                REG_QUOTE_COUNT: quote_count_reg <= pwdata[2:0];
                default:         quote_bytes_reg <= quote_bytes_reg;
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        unique case (paddr[2])
            REG_QUOTE_BYTES: prdata = quote_bytes_reg;
            REG_QUOTE_COUNT: prdata = {29'd0, quote_count_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign quote_bytes = quote_bytes_reg;
    assign quote_count = quote_count_reg;

endmodule

FILE: design/ctok_step.sv
// ----------------------------------------------------------------------------
// ctok_step: per-character scan logic
// Classifies one character against the current scan mode and produces up to
// two results together with the next scan state.
// ----------------------------------------------------------------------------
module ctok_step
    import ctok_pkg::*;
(
    input  logic [2:0]  mode,
    input  logic [7:0]  open_quote,
    input  logic        spaces_seen,
    input  logic        kind,
    input  logic [7:0]  char_byte,
    input  logic [31:0] quote_bytes,
    input  logic [2:0]  quote_count,
    output step_t       step
);

    // Outcome of handling a character while between tokens.
    typedef struct packed {
        logic       emit;
        res_t       res;
        logic [2:0] mode_next;
        logic       spaces_next;
        logic       load_quote;
    } idle_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic res_t make_res(input logic [1:0] cls, input logic [7:0] b,
                                      input logic valid, input logic start,
                                      input logic sp, input logic close);
        res_t r;
        r.token_class  = cls;
        r.out_byte     = valid ? b : 8'd0;
        r.byte_valid   = valid;
        r.starts_token = start;
        r.space_before = start & sp;
        r.closes_token = close;
        r.last_result  = 1'b0;
        return r;
    endfunction

    logic  eof;
    logic  quote_hit;
    logic  name_char;
    idle_t idle;
    res_t  close_res;
    res_t  data_res;

    assign eof       = (kind == KIND_EOF);
    assign name_char = is_alpha(char_byte) || is_digit(char_byte) || (char_byte == CH_UNDER);

    // Quote match over the active slots; counts above four enable all slots.
    always_comb
    begin
        quote_hit = 1'b0;
        for (int k = 0; k < QUOTE_SLOTS; k++)
        begin
            if (quote_count > 3'(k) && quote_bytes[8*k +: 8] == char_byte)
                quote_hit = 1'b1;
        end
    end

    // Character handling between tokens.
    always_comb
    begin
        idle.emit        = 1'b1;
        idle.res         = make_res(CLS_SIGN, char_byte, 1'b1, 1'b1, spaces_seen, 1'b1);
        idle.mode_next   = MODE_IDLE;
        idle.spaces_next = 1'b0;
        idle.load_quote  = 1'b0;
        priority if (eof)
        begin
            idle.res = make_res(CLS_END, 8'd0, 1'b0, 1'b1, spaces_seen, 1'b1);
        end
        else if (is_space(char_byte))
        begin
            idle.emit        = 1'b0;
            idle.spaces_next = 1'b1;
        end
        else if (char_byte == CH_HASH)
        begin
            idle.emit        = 1'b0;
            idle.spaces_next = 1'b1;
            idle.mode_next   = MODE_COMMENT;
        end
        else if (is_digit(char_byte))
        begin
            idle.res       = make_res(CLS_INT, char_byte, 1'b1, 1'b1, spaces_seen, 1'b0);
            idle.mode_next = MODE_INT;
        end
        else if (is_alpha(char_byte) || char_byte == CH_UNDER)
        begin
            idle.res       = make_res(CLS_NAME, char_byte, 1'b1, 1'b1, spaces_seen, 1'b0);
            idle.mode_next = MODE_NAME;
        end
        else if (quote_hit)
        begin
            idle.res        = make_res(CLS_NAME, 8'd0, 1'b0, 1'b1, spaces_seen, 1'b0);
            idle.mode_next  = MODE_STR;
            idle.load_quote = 1'b1;
        end
        else
        begin
            idle.emit = 1'b1;
        end
    end

    // Mode-dependent step.
    always_comb
    begin
        step.r0              = make_res(CLS_END, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        step.r1              = step.r0;
        step.n               = 2'd0;
        step.mode_next       = mode;
        step.open_quote_next = open_quote;
        step.spaces_next     = spaces_seen;
        close_res = make_res(CLS_NAME, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        data_res  = make_res(CLS_NAME, char_byte, 1'b1, 1'b0, 1'b0, 1'b0);

        unique case (mode)
            MODE_COMMENT:
            begin
                if (eof)
                begin
                    step.r0          = make_res(CLS_END, 8'd0, 1'b0, 1'b1, spaces_seen, 1'b1);
                    step.n           = 2'd1;
                    step.mode_next   = MODE_IDLE;
                    step.spaces_next = 1'b0;
                end
                else if (char_byte == CH_NL)
                begin
                    step.mode_next = MODE_IDLE;
                end
            end
            MODE_INT, MODE_NAME:
            begin
                if (!eof && (mode == MODE_INT ? is_digit(char_byte) : name_char))
                begin
                    step.r0             = data_res;
                    step.r0.token_class = (mode == MODE_INT) ? CLS_INT : CLS_NAME;
                    step.n              = 2'd1;
                end
                else
                begin
                    // The run closes; the foreign character is then handled anew.
                    step.r0             = close_res;
                    step.r0.token_class = (mode == MODE_INT) ? CLS_INT : CLS_NAME;
                    step.r1             = idle.res;
                    step.n              = idle.emit ? 2'd2 : 2'd1;
                    step.mode_next      = idle.mode_next;
                    step.spaces_next    = idle.spaces_next;
                    if (idle.load_quote)
                        step.open_quote_next = char_byte;
                end
            end
            MODE_STR:
            begin
                if (eof)
                begin
                    // An unfinished string is closed ahead of the end token.
                    step.r0              = close_res;
                    step.r1              = make_res(CLS_END, 8'd0, 1'b0, 1'b1,
                                                    spaces_seen, 1'b1);
                    step.n               = 2'd2;
                    step.open_quote_next = 8'd0;
                    step.mode_next       = MODE_IDLE;
                    step.spaces_next     = 1'b0;
                end
                else if (char_byte == open_quote)
                begin
                    step.r0              = close_res;
                    step.n               = 2'd1;
                    step.open_quote_next = 8'd0;
                    step.mode_next       = MODE_IDLE;
                end
                else
                begin
                    step.r0 = data_res;
                    step.n  = 2'd1;
                end
            end
            default:
            begin
                // Idle, and any code that is not a scan mode.
                step.r0          = idle.res;
                step.n           = idle.emit ? 2'd1 : 2'd0;
                step.mode_next   = idle.mode_next;
                step.spaces_next = idle.spaces_next;
                if (idle.load_quote)
                    step.open_quote_next = char_byte;
            end
        endcase

        // Mark the final result of this character.
        if (step.n == 2'd2)
            step.r1.last_result = 1'b1;
        else
            step.r0.last_result = 1'b1;
    end

endmodule

FILE: design/char_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// char_stream_tokenizer: streaming lexical tokenizer
// Top level: input register, scan state, per-character step logic, a
// two-entry result queue and the configuration registers.
// ----------------------------------------------------------------------------
// The tokenizer takes one character or end mark per input transaction and
// sends token results on the output channel, one result per transaction,
// with marks that open and close each token. An input item is held in the
// input register, where the scan logic classifies it against the current
// mode and pushes its results into a two-entry output queue. A new item is
// taken every cycle as long as each causes at most one result and the sink
// keeps up; an item that closes a run or string and opens another token
// causes two results, so the rate is then set by the output port at one
// result per cycle. Whitespace between tokens and comment characters cause
// no result and never wait for room in the queue. The user must write the
// quote registers only while no item is in flight; the block itself does
// not enforce this.
module char_stream_tokenizer
    import ctok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ctok_in_if.sink     in,
    ctok_out_if.source  out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic [31:0] quote_bytes;
    logic [2:0]  quote_count;

    // Input register.
    logic        item_valid_reg;
    logic        item_kind_reg;
    logic [7:0]  item_byte_reg;

    // Scan state.
    logic [2:0]  mode_reg;
    logic [7:0]  open_quote_reg;
    logic        spaces_reg;

    // Output queue.
    res_t        fifo_reg [OUT_DEPTH];
    logic        rd_ptr_reg;
    logic        wr_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] free_slots;

    step_t       step;
    logic        pop;
    logic        fire;
    logic        take;
    res_t        head;

    ctok_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .quote_bytes (quote_bytes),
        .quote_count (quote_count)
    );

    ctok_step u_step (
        .mode        (mode_reg),
        .open_quote  (open_quote_reg),
        .spaces_seen (spaces_reg),
        .kind        (item_kind_reg),
        .char_byte   (item_byte_reg),
        .quote_bytes (quote_bytes),
        .quote_count (quote_count),
        .step        (step)
    );

    // Handshake: the held item is processed when the queue has room for all
    // of its results, counting the slot freed by a result leaving this cycle.
    assign pop        = out.valid && out.ready;
    assign free_slots = CNT_W'(OUT_DEPTH) - count_reg + CNT_W'(pop);
    assign fire       = item_valid_reg && (CNT_W'(step.n) <= free_slots);
    assign in.ready   = !item_valid_reg || fire;
    assign take       = in.valid && in.ready;
    assign count_next = count_reg + CNT_W'(fire ? step.n : 2'd0) - CNT_W'(pop);

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in.ready)
            item_valid_reg <= in.valid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_kind_reg <= in.kind;
            item_byte_reg <= in.char_byte;
        end
    end

    // Scan state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            open_quote_reg <= 8'd0;
            spaces_reg     <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg       <= step.mode_next;
            open_quote_reg <= step.open_quote_next;
            spaces_reg     <= step.spaces_next;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (fire && step.n == 2'd1)
                wr_ptr_reg <= ~wr_ptr_reg;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (fire && step.n != 2'd0)
            fifo_reg[wr_ptr_reg] <= step.r0;
        if (fire && step.n == 2'd2)
            fifo_reg[~wr_ptr_reg] <= step.r1;
    end

    // Output channel.
    assign head             = fifo_reg[rd_ptr_reg];
    assign out.valid        = (count_reg != '0);
    assign out.token_class  = head.token_class;
    assign out.out_byte     = head.out_byte;
    assign out.byte_valid   = head.byte_valid;
    assign out.starts_token = head.starts_token;
    assign out.space_before = head.space_before;
    assign out.closes_token = head.closes_token;
    assign out.last_result  = head.last_result;

endmodule

FILE: design/ctok_checker.sv
// ----------------------------------------------------------------------------
// ctok_checker: port-level checks of the character stream tokenizer
// Watches the output channel and the configuration port for token framing,
// end token shape, stall behavior and register read-back.
// ----------------------------------------------------------------------------
module ctok_checker
    import ctok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  out_token_class,
    input  logic [7:0]  out_out_byte,
    input  logic        out_byte_valid,
    input  logic        out_starts_token,
    input  logic        out_closes_token,
    input  logic        out_last_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata
);

    logic open_reg;
    logic xfer;

    assign xfer = out_valid && out_ready;

    // Tracks whether a token has been opened and not yet closed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= 1'b0;
        else if (xfer)
        begin
            if (out_closes_token)
                open_reg <= 1'b0;
            else if (out_starts_token)
                open_reg <= 1'b1;
        end
    end

    // A token opens only between tokens, and every other result lies inside one.
    a_framing: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> (out_starts_token == !open_reg))
        else $error("token start mark does not match framing");

    // The end token opens, closes, carries no byte and ends its item.
    a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_token_class == CLS_END) |->
            (out_starts_token && out_closes_token && !out_byte_valid && out_last_result))
        else $error("malformed end token");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_token_class) && $stable(out_out_byte)
             && $stable(out_starts_token) && $stable(out_closes_token)))
        else $error("result changed while stalled");

    // A quote byte register reads back what was last written.
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[2] == REG_QUOTE_BYTES)
            ##1 (psel && !pwrite && paddr[2] == REG_QUOTE_BYTES)
            |-> (prdata == $past(pwdata)))
        else $error("quote byte register read-back mismatch");

endmodule

bind char_stream_tokenizer ctok_checker u_ctok_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out.valid),
    .out_ready        (out.ready),
    .out_token_class  (out.token_class),
    .out_out_byte     (out.out_byte),
    .out_byte_valid   (out.byte_valid),
    .out_starts_token (out.starts_token),
    .out_closes_token (out.closes_token),
    .out_last_result  (out.last_result),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the character stream tokenizer
// Drives character and end-of-input transactions with random gaps, tracks the
// scan state in its own tokenizer model, and checks every token result field
// by field against the oldest predicted result. The quote registers are
// reprogrammed between phases, and the output side stalls at random.
// ----------------------------------------------------------------------------
module testbench;
    import ctok_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_TOKENS  = 130;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ctok_in_if  in_ch ();
    ctok_out_if out_ch ();

    char_stream_tokenizer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in      (in_ch),
        .out     (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Tokenizer model: configuration copy and scan state.
    logic [31:0] quote_set;
    logic [2:0]  quote_active;
    logic [2:0]  lex_mode;
    logic [7:0]  string_quote;
    logic        blank_before;

    res_t step_out[$];
    res_t expected_tokens[$];

    // Run bookkeeping.
    int errors           = 0;
    int items_accepted   = 0;
    int productive_items = 0;
    int results_checked  = 0;
    int tokens_by_class[4];
    bit src_gaps_on      = 1'b0;
    bit sink_stalls_on   = 1'b0;

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------------
    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_letter(c) || is_numeral(c) || c == CH_UNDER;
    endfunction

    // Only the active slots are compared; counts above the slot number saturate.
    function automatic logic is_quote_char(input logic [7:0] c);
        int active;
        int k;
        active = (quote_active > 3'(QUOTE_SLOTS)) ? QUOTE_SLOTS : int'(quote_active);
        for (k = 0; k < active; k++)
            if (quote_set[8 * k +: 8] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Tokenizer model
    // ------------------------------------------------------------------------
    function automatic void add_result(input logic [1:0] cls, input logic [7:0] c,
                                       input logic valid, input logic start,
                                       input logic sp, input logic close);
        res_t r;
        r.token_class  = cls;
        r.out_byte     = valid ? c : 8'h00;
        r.byte_valid   = valid;
        r.starts_token = start;
        r.space_before = start & sp;
        r.closes_token = close;
        r.last_result  = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void emit_end_token();
        add_result(CLS_END, 8'h00, 1'b0, 1'b1, blank_before, 1'b1);
        blank_before = 1'b0;
        lex_mode     = MODE_IDLE;
    endfunction

    // A byte seen between tokens: skip it, start a comment or open a token.
    function automatic void scan_between_tokens(input logic kind, input logic [7:0] c);
        lex_mode = MODE_IDLE;
        if (kind == KIND_EOF)
        begin
            emit_end_token();
        end
        else if (is_blank(c))
        begin
            blank_before = 1'b1;
        end
        else if (c == CH_HASH)
        begin
            blank_before = 1'b1;
            lex_mode     = MODE_COMMENT;
        end
        else if (is_numeral(c))
        begin
            add_result(CLS_INT, c, 1'b1, 1'b1, blank_before, 1'b0);
            blank_before = 1'b0;
            lex_mode     = MODE_INT;
        end
        else if (is_letter(c) || c == CH_UNDER)
        begin
            add_result(CLS_NAME, c, 1'b1, 1'b1, blank_before, 1'b0);
            blank_before = 1'b0;
            lex_mode     = MODE_NAME;
        end
        else if (is_quote_char(c))
        begin
            add_result(CLS_NAME, 8'h00, 1'b0, 1'b1, blank_before, 1'b0);
            blank_before = 1'b0;
            string_quote = c;
            lex_mode     = MODE_STR;
        end
        else
        begin
            add_result(CLS_SIGN, c, 1'b1, 1'b1, blank_before, 1'b1);
            blank_before = 1'b0;
        end
    endfunction

    // Advance the model by one accepted transaction and queue its results.
    function automatic void tokenize_item(input logic kind, input logic [7:0] c);
        int idx;
        step_out.delete();
        case (lex_mode)
            MODE_COMMENT:
            begin
                if (kind == KIND_EOF)
                    emit_end_token();
                else if (c == CH_NL)
                    lex_mode = MODE_IDLE;
            end
            MODE_INT:
            begin
                if (kind == KIND_CHAR && is_numeral(c))
                begin
                    add_result(CLS_INT, c, 1'b1, 1'b0, 1'b0, 1'b0);
                end
                else
                begin
                    add_result(CLS_INT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                    scan_between_tokens(kind, c);
                end
            end
            MODE_NAME:
            begin
                if (kind == KIND_CHAR && is_ident_char(c))
                begin
                    add_result(CLS_NAME, c, 1'b1, 1'b0, 1'b0, 1'b0);
                end
                else
                begin
                    add_result(CLS_NAME, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                    scan_between_tokens(kind, c);
                end
            end
            MODE_STR:
            begin
                if (kind == KIND_EOF)
                begin
                    add_result(CLS_NAME, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                    string_quote = 8'h00;
                    emit_end_token();
                end
                else if (c == string_quote)
                begin
                    add_result(CLS_NAME, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                    string_quote = 8'h00;
                    lex_mode     = MODE_IDLE;
                end
                else
                begin
                    add_result(CLS_NAME, c, 1'b1, 1'b0, 1'b0, 1'b0);
                end
            end
            default: scan_between_tokens(kind, c);
        endcase
        if (step_out.size() > 0)
        begin
            idx = step_out.size() - 1;
            step_out[idx].last_result = 1'b1;
            productive_items++;
        end
        foreach (step_out[i])
            expected_tokens.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    function automatic void check_result();
        res_t want;
        if (expected_tokens.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result: class %0d byte %02h valid %0b", $time,
                     out_ch.token_class, out_ch.out_byte, out_ch.byte_valid);
        end
        else
        begin
            want = expected_tokens.pop_front();
            compare_field("token_class", want.token_class, out_ch.token_class);
            compare_field("out_byte", want.out_byte, out_ch.out_byte);
            compare_field("byte_valid", want.byte_valid, out_ch.byte_valid);
            compare_field("starts_token", want.starts_token, out_ch.starts_token);
            compare_field("space_before", want.space_before, out_ch.space_before);
            compare_field("closes_token", want.closes_token, out_ch.closes_token);
            compare_field("last_result", want.last_result, out_ch.last_result);
            if (want.starts_token)
                tokens_by_class[want.token_class]++;
            results_checked++;
        end
    endfunction

    // Check outgoing results first, then predict from the incoming transaction.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_result();
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            items_accepted++;
            tokenize_item(in_ch.kind, in_ch.char_byte);
        end
    end

    // ------------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then long.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Output side: random stalls when enabled.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_stalls_on && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (1 + pick_gap()) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks; each starts and ends at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic [7:0] c);
        int gap;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.char_byte <= c;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic wait_for_results(input int settle);
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_tokens.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_register(input logic index, input logic [31:0] value);
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_QUOTE_BYTES)
            quote_set = value;
        else
            quote_active = value[2:0];
        @(negedge clk);
    endtask

    function automatic logic [7:0] name_start_char();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'h41 + 8'(r);
        if (r < 52)
            return 8'h61 + 8'(r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] name_body_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 8'h30 + 8'($urandom_range(0, 9));
        return name_start_char();
    endfunction

    // One well-formed token or separator with random content, or noise.
    task automatic send_random_token();
        int         pick;
        int         len;
        int         n;
        int         slots;
        logic [7:0] c;
        logic [7:0] q;
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            len = $urandom_range(1, 6);
            for (n = 0; n < len; n++)
                send_item(KIND_CHAR, 8'h30 + 8'($urandom_range(0, 9)));
        end
        else if (pick < 36)
        begin
            send_item(KIND_CHAR, name_start_char());
            len = $urandom_range(0, 6);
            for (n = 0; n < len; n++)
                send_item(KIND_CHAR, name_body_char());
        end
        else if (pick < 52)
        begin
            // Quoted string, sometimes cut short by end of input.
            slots = (quote_active > 3'(QUOTE_SLOTS)) ? QUOTE_SLOTS : int'(quote_active);
            if (slots == 0)
            begin
                q = 8'($urandom_range(0, 255));
            end
            else
            begin
                n = $urandom_range(0, slots - 1);
                q = quote_set[8 * n +: 8];
            end
            send_item(KIND_CHAR, q);
            len = $urandom_range(0, 8);
            for (n = 0; n < len; n++)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == q);
                send_item(KIND_CHAR, c);
            end
            if ($urandom_range(0, 9) == 0)
                send_item(KIND_EOF, 8'($urandom_range(0, 255)));
            else
                send_item(KIND_CHAR, q);
        end
        else if (pick < 66)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (is_blank(c) || is_ident_char(c) || c == CH_HASH || is_quote_char(c));
            send_item(KIND_CHAR, c);
        end
        else if (pick < 76)
        begin
            len = $urandom_range(1, 3);
            for (n = 0; n < len; n++)
            begin
                c = 8'($urandom_range(9, 14));
                send_item(KIND_CHAR, (c == 8'd14) ? 8'd32 : c);
            end
        end
        else if (pick < 82)
        begin
            send_item(KIND_CHAR, CH_HASH);
            len = $urandom_range(0, 5);
            for (n = 0; n < len; n++)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_NL);
                send_item(KIND_CHAR, c);
            end
            if ($urandom_range(0, 9) == 0)
                send_item(KIND_EOF, 8'($urandom_range(0, 255)));
            else
                send_item(KIND_CHAR, CH_NL);
        end
        else if (pick < 88)
        begin
            send_item(KIND_EOF, 8'($urandom_range(0, 255)));
        end
        else
        begin
            send_item(($urandom_range(0, 19) == 0) ? KIND_EOF : KIND_CHAR,
                      8'($urandom_range(0, 255)));
        end
    endtask

    // Send random tokens until the given number of items have caused results.
    task automatic random_stream(input int target);
        int first;
        first = productive_items;
        while (productive_items - first < target)
            send_random_token();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Field extremes and each special case under the reset quote setting.
    task automatic test_directed_tokens();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        send_item(KIND_CHAR, " ");        // leading blank sets the flag
        send_item(KIND_CHAR, CH_UNDER);   // name opened by underscore
        send_item(KIND_CHAR, "Z");
        send_item(KIND_CHAR, "9");        // digit inside a name
        send_item(KIND_CHAR, 8'h0D);      // carriage return closes the name
        send_item(KIND_CHAR, 8'h09);
        send_item(KIND_CHAR, "0");        // integer run
        send_item(KIND_CHAR, "9");
        send_item(KIND_CHAR, "a");        // closes the integer and opens a name
        send_item(KIND_CHAR, 8'h22);      // closes the name and opens a string
        send_item(KIND_CHAR, 8'hFF);
        send_item(KIND_CHAR, 8'h22);
        send_item(KIND_CHAR, 8'h22);      // empty string
        send_item(KIND_CHAR, 8'h22);
        send_item(KIND_CHAR, 8'h80);      // high byte is a sign
        send_item(KIND_CHAR, 8'h00);      // zero is a sign while no slot holds it
        send_item(KIND_CHAR, CH_HASH);    // comment up to the newline
        send_item(KIND_CHAR, "q");
        send_item(KIND_CHAR, CH_NL);
        send_item(KIND_CHAR, 8'h22);      // string left open at end of input
        send_item(KIND_EOF, 8'hFF);
        send_item(KIND_CHAR, "~");
        send_item(KIND_CHAR, CH_HASH);
        send_item(KIND_EOF, 8'h00);       // end of input inside a comment
        send_item(KIND_EOF, 8'h5A);       // end of input between tokens
    endtask

    task automatic run_quote_phase(input logic [31:0] quotes, input logic [2:0] count);
        wait_for_results(SETTLE_CYCLES);
        write_register(REG_QUOTE_BYTES, quotes);
        write_register(REG_QUOTE_COUNT, {29'd0, count});
        src_gaps_on    = ($urandom_range(0, 2) != 0);
        sink_stalls_on = ($urandom_range(0, 2) != 0);
        random_stream(PHASE_TOKENS);
    endtask

    // Random streams under several quote settings, extremes included.
    task automatic test_quote_settings();
        run_quote_phase(32'h0000_0022, 3'd1);
        run_quote_phase(32'h6027_7C22, 3'd4);
        run_quote_phase(32'h0000_0000, 3'd7);   // zero byte is a quote
        run_quote_phase(32'hFFFF_FFFF, 3'd0);   // no quotes at all
        run_quote_phase(32'h2023_5F41, 3'd3);   // letter, underscore, hash never quote
        run_quote_phase(32'h0080_2F39, 3'd5);   // count above the slot number
        run_quote_phase(32'hFF7E_3A27, 3'd2);
        run_quote_phase($urandom(), 3'($urandom_range(0, 7)));
    endtask

    // Back-pressure on each side alone, both, and pauses until drained.
    task automatic test_flow_control();
        int round;
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        random_stream(100);
        sink_stalls_on = 1'b1;
        random_stream(100);
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b0;
        random_stream(100);
        sink_stalls_on = 1'b1;
        for (round = 0; round < 4; round++)
        begin
            random_stream(25);
            wait_for_results(0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_CHAR;
        in_ch.char_byte = 8'h00;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 3'd0;
        pwdata          = 32'd0;
        quote_set       = 32'd34;
        quote_active    = 3'd1;
        lex_mode        = MODE_IDLE;
        string_quote    = 8'h00;
        blank_before    = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_tokens();
        test_quote_settings();
        test_flow_control();
        wait_for_results(SETTLE_CYCLES);

        $display("Run covered %0d input items and %0d checked results under 8 quote settings,",
                 items_accepted, results_checked);
        $display("with %0d integers, %0d names or strings, %0d signs and %0d end tokens.",
                 tokens_by_class[CLS_INT], tokens_by_class[CLS_NAME],
                 tokens_by_class[CLS_SIGN], tokens_by_class[CLS_END]);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial
    begin
        #(20_000_000);
        $display("ERROR: time limit reached with %0d results outstanding",
                 expected_tokens.size());
        $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: char_stream_tokenizer.f
design/ctok_pkg.sv
design/ctok_ifs.sv
design/ctok_regs.sv
design/ctok_step.sv
design/char_stream_tokenizer.sv
design/ctok_checker.sv
tb/testbench.sv
